// ----- design/fpwc_pkg.sv -----
// Shared widths, constants and beat structs for the flash phrase write combiner.
`default_nettype none
package fpwc_pkg;

	localparam int ADDR_W    = 32;
	localparam int BYTE_W    = 8;
	localparam int OUT_BYTES = 8;
	localparam int WDATA_W   = OUT_BYTES * BYTE_W;
	// reciprocal of the phrase size fits 33 bits for any size up to 16
	localparam int RECIP_W   = ADDR_W + 1;
	localparam int PROD_W    = ADDR_W + RECIP_W;

	localparam logic [BYTE_W-1:0] PAD_BYTE = 8'hFF;

	// item leaving the address stage
	typedef struct packed {
		logic              mode;
		logic [ADDR_W-1:0] addr;
		logic [BYTE_W-1:0] data;
		logic [PROD_W-1:0] prod;
	} addr_item_t;

	// one emitted phrase
	typedef struct packed {
		logic [ADDR_W-1:0]  waddr;
		logic [WDATA_W-1:0] wdata;
		logic               last;
	} result_t;

	// up to two phrases produced by one item
	typedef struct packed {
		logic [1:0] count;
		result_t    first;
		result_t    second;
	} result_pair_t;

endpackage
`default_nettype wire

// ----- design/fpwc_addr_stage.sv -----
// Input register, byte address tracking and reciprocal multiply for the phrase split.
`default_nettype none
module fpwc_addr_stage #(
	parameter int PHRASE_BYTES = 8
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic                        mode,
	input  wire logic                        record_start,
	input  wire logic [fpwc_pkg::ADDR_W-1:0] address,
	input  wire logic [fpwc_pkg::BYTE_W-1:0] image_byte,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output fpwc_pkg::addr_item_t             item_s2
);
	import fpwc_pkg::*;

	localparam int SHIFT = $clog2(PHRASE_BYTES);
	// ceil(2^(32+SHIFT) / PHRASE_BYTES): exact floor division for any 32-bit address
	localparam logic [63:0] RECIP64 =
		((64'd1 << (ADDR_W + SHIFT)) + 64'(PHRASE_BYTES) - 64'd1) / 64'(PHRASE_BYTES);
	localparam logic [RECIP_W-1:0] RECIP = RECIP64[RECIP_W-1:0];

	logic              valid_s1;
	logic              mode_s1;
	logic              rstart_s1;
	logic [ADDR_W-1:0] address_s1;
	logic [BYTE_W-1:0] data_s1;
	logic              valid_s2;
	logic [ADDR_W-1:0] next_addr_q;

	logic              go_s1;
	logic [ADDR_W-1:0] addr;
	logic [PROD_W-1:0] prod;

	// handshake
	assign go_s1     = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready  = !valid_s1 || go_s1;
	assign out_valid = valid_s2;

	// byte address and quotient product
	assign addr = rstart_s1 ? address_s1 : next_addr_q;
	assign prod = PROD_W'(addr) * PROD_W'(RECIP);

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			next_addr_q <= '0;
		end else begin
			if (in_ready)
				valid_s1 <= in_valid;
			if (go_s1)
				valid_s2 <= 1'b1;
			else if (out_ready)
				valid_s2 <= 1'b0;
			// flush beats leave the running address alone
			if (go_s1 && !mode_s1)
				next_addr_q <= addr + ADDR_W'(1);
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			mode_s1    <= mode;
			rstart_s1  <= record_start;
			address_s1 <= address;
			data_s1    <= image_byte;
		end
		if (go_s1) begin
			item_s2.mode <= mode_s1;
			item_s2.addr <= addr;
			item_s2.data <= data_s1;
			item_s2.prod <= prod;
		end
	end

endmodule
`default_nettype wire

// ----- design/fpwc_phrase_stage.sv -----
// Open phrase state: continuity check, byte placement, padding and phrase emission.
`default_nettype none
module fpwc_phrase_stage #(
	parameter int PHRASE_BYTES = 8
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire fpwc_pkg::addr_item_t item_s2,
	input  wire logic [1:0]           space,
	output logic                      push,
	output fpwc_pkg::result_pair_t    pair
);
	import fpwc_pkg::*;

	localparam int SHIFT = $clog2(PHRASE_BYTES);
	localparam int FW    = $clog2(PHRASE_BYTES + 1);
	localparam int KEEP  = (PHRASE_BYTES < OUT_BYTES) ? PHRASE_BYTES : OUT_BYTES;

	logic [BYTE_W-1:0] bytes_q [KEEP];
	logic [ADDR_W-1:0] phrase_addr_q;
	logic [FW-1:0]     fill_q;
	logic              holding_q;

	logic [ADDR_W-1:0]  quot;
	logic [ADDR_W-1:0]  base;
	logic [FW-1:0]      offset;
	logic [ADDR_W-1:0]  cont_addr;
	logic               brk;
	logic               start_new;
	logic [FW-1:0]      slot;
	logic [FW-1:0]      nf;
	logic               full;
	logic [BYTE_W-1:0]  nb [KEEP];
	logic [WDATA_W-1:0] old_data;
	logic [WDATA_W-1:0] new_data;
	logic [ADDR_W-1:0]  new_addr;
	logic [1:0]         n;

	// phrase split of the byte address
	assign quot   = ADDR_W'(item_s2.prod >> (ADDR_W + SHIFT));
	assign base   = quot * ADDR_W'(PHRASE_BYTES);
	assign offset = FW'(item_s2.addr - base);

	// continuity against the open phrase
	assign cont_addr = phrase_addr_q + ADDR_W'(fill_q);
	assign brk       = holding_q && (item_s2.addr != cont_addr);
	assign start_new = !holding_q || brk;
	assign slot      = start_new ? offset : fill_q;
	assign nf        = slot + FW'(1);
	assign full      = (nf == FW'(PHRASE_BYTES));
	assign new_addr  = start_new ? base : phrase_addr_q;

	// byte lanes: next contents, old phrase view, new phrase view
	for (genvar g = 0; g < OUT_BYTES; g++) begin : g_lane
		if (g < KEEP) begin : g_kept
			always_comb begin
				if (FW'(g) == slot)
					nb[g] = item_s2.data;
				else if (start_new && (FW'(g) < slot))
					nb[g] = PAD_BYTE;
				else
					nb[g] = bytes_q[g];
			end
			assign old_data[g*BYTE_W +: BYTE_W] = (FW'(g) < fill_q) ? bytes_q[g] : PAD_BYTE;
			assign new_data[g*BYTE_W +: BYTE_W] = nb[g];
		end else begin : g_pad
			assign old_data[g*BYTE_W +: BYTE_W] = PAD_BYTE;
			assign new_data[g*BYTE_W +: BYTE_W] = PAD_BYTE;
		end
	end

	// results for this item
	always_comb begin
		pair.first  = '{waddr: phrase_addr_q, wdata: old_data, last: 1'b1};
		pair.second = '{waddr: new_addr, wdata: new_data, last: 1'b1};
		if (item_s2.mode) begin
			n = holding_q ? 2'd1 : 2'd0;
		end else begin
			priority if (brk && full) begin
				n                = 2'd2;
				pair.first.last  = 1'b0;
			end else if (brk) begin
				n = 2'd1;
			end else if (full) begin
				n          = 2'd1;
				pair.first = pair.second;
			end else begin
				n = 2'd0;
			end
		end
		pair.count = n;
	end

	assign push     = in_valid && (n <= space);
	assign in_ready = !in_valid || push;

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q    <= '0;
			holding_q <= 1'b0;
		end else if (push) begin
			if (item_s2.mode) begin
				fill_q    <= '0;
				holding_q <= 1'b0;
			end else begin
				fill_q    <= full ? '0 : nf;
				holding_q <= !full;
			end
		end
	end

	// phrase contents and address
	always_ff @(posedge clk) begin
		if (push && !item_s2.mode) begin
			for (int i = 0; i < KEEP; i++)
				bytes_q[i] <= nb[i];
			if (start_new)
				phrase_addr_q <= base;
		end
	end

endmodule
`default_nettype wire

// ----- design/fpwc_out_fifo.sv -----
// Two-entry result queue taking up to two phrases per cycle, one beat out.
`default_nettype none
module fpwc_out_fifo (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   push,
	input  wire fpwc_pkg::result_pair_t pair,
	output logic [1:0]                  space,
	output logic                        out_valid,
	input  wire logic                   out_ready,
	output fpwc_pkg::result_t           head
);
	import fpwc_pkg::*;

	result_t    slot_q [2];
	logic       rd_q;
	logic       wr_q;
	logic [1:0] count_q;
	logic       pop;
	logic [1:0] n_in;

	assign out_valid = (count_q != 2'd0);
	assign pop       = out_valid && out_ready;
	assign space     = 2'd2 - count_q + {1'b0, pop};
	assign n_in      = push ? pair.count : 2'd0;
	assign head      = slot_q[rd_q];

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q    <= 1'b0;
			wr_q    <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (pop)
				rd_q <= !rd_q;
			wr_q    <= wr_q ^ n_in[0];
			count_q <= count_q + n_in - {1'b0, pop};
		end
	end

	// entries
	always_ff @(posedge clk) begin
		if (n_in != 2'd0)
			slot_q[wr_q] <= pair.first;
		if (n_in == 2'd2)
			slot_q[!wr_q] <= pair.second;
	end

endmodule
`default_nettype wire

// ----- design/flash_phrase_write_combiner_core.sv -----
// Top level of the flash phrase write combiner.
//
// Slave stream: one beat per data byte or flush. A data beat with record_start
// set carries its byte address; otherwise the byte goes to the address after
// the previous byte. Bytes pack into aligned phrases of PHRASE_BYTES bytes.
// Master stream: one beat per emitted phrase (aligned address and 64-bit data,
// unfilled bytes 0xFF); tlast marks the last phrase caused by one input beat.
// A beat may cause none, one or two phrases (break in continuity plus a full
// phrase on the same byte).
// Throughput: one input beat per cycle, set by the phrase state update, while
// the output queue has room; an item, also one yielding two phrases, holds the
// input only when the two-entry output queue lacks room.
// Path from input acceptance to the first output beat: input register,
// address/multiply register, output queue.
// Reset: no open phrase, running byte address zero, pipeline and queue empty.
// A stalled receiver fills the output queue, then back-pressure reaches
// s_tready; nothing is dropped.
`default_nettype none
module flash_phrase_write_combiner_core #(
	parameter int PHRASE_BYTES = 8
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [39:0] s_tdata,   // address[31:0], image_byte[39:32]
	input  wire logic [1:0]  s_tuser,   // mode[0], record_start[1]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [95:0]      m_tdata,   // write_address[31:0], write_data[95:32]
	output logic             m_tlast    // last_of_run
);
	import fpwc_pkg::*;

	addr_item_t   item_s2;
	logic         item_valid;
	logic         item_ready;
	logic [1:0]   space;
	logic         push;
	result_pair_t pair;
	result_t      head;

	fpwc_addr_stage #(.PHRASE_BYTES(PHRASE_BYTES)) u_addr (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (s_tvalid),
		.in_ready     (s_tready),
		.mode         (s_tuser[0]),
		.record_start (s_tuser[1]),
		.address      (s_tdata[31:0]),
		.image_byte   (s_tdata[39:32]),
		.out_valid    (item_valid),
		.out_ready    (item_ready),
		.item_s2      (item_s2)
	);

	fpwc_phrase_stage #(.PHRASE_BYTES(PHRASE_BYTES)) u_phrase (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (item_valid),
		.in_ready (item_ready),
		.item_s2  (item_s2),
		.space    (space),
		.push     (push),
		.pair     (pair)
	);

	fpwc_out_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.pair      (pair),
		.space     (space),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.head      (head)
	);

	assign m_tdata = {head.wdata, head.waddr};
	assign m_tlast = head.last;

endmodule
`default_nettype wire

// ----- design/fpwc_checker.sv -----
// Port-level assertions for the flash phrase write combiner, bound to the top level.
`default_nettype none
module fpwc_checker #(
	parameter int PHRASE_BYTES = 8
) (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [95:0] m_tdata,
	input wire logic        m_tlast
);

	function automatic logic [63:0] pad_mask();
		logic [63:0] mask;
		mask = '0;
		for (int i = 0; i < 8; i++)
			if (i >= PHRASE_BYTES)
				mask[i*8 +: 8] = 8'hFF;
		return mask;
	endfunction

	localparam logic [63:0] PAD_MASK = pad_mask();

	logic seen_q;

	// any input beat taken since reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			seen_q <= 1'b0;
		else if (s_tvalid && s_tready)
			seen_q <= 1'b1;
	end

	// stalled output beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("output beat changed while stalled");

	// no phrase without an input
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!seen_q |-> !m_tvalid)
		else $error("output beat before any input");

	// second phrase of a pair is already queued
	a_pair: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && !m_tlast |=> m_tvalid)
		else $error("first phrase of a pair not followed at once");

	// bytes beyond the phrase size read as padding
	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ((m_tdata[95:32] & PAD_MASK) == PAD_MASK))
		else $error("bytes beyond phrase size not padded");

endmodule

bind flash_phrase_write_combiner_core fpwc_checker #(.PHRASE_BYTES(PHRASE_BYTES)) u_chk (.*);
`default_nettype wire

// ----- test/flash_phrase_write_combiner_core_tb.sv -----
// Self-checking testbench for the flash phrase write combiner: directed and random byte streams.
`default_nettype none
module flash_phrase_write_combiner_core_tb;
	import fpwc_pkg::*;

	localparam int PHRASE     = 8;
	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_WAIT  = 20;
	localparam logic MODE_DATA  = 1'b0;
	localparam logic MODE_FLUSH = 1'b1;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [39:0] s_tdata;   // address[31:0], image_byte[39:32]
	logic [1:0]  s_tuser;   // mode[0], record_start[1]
	logic        m_tvalid;
	logic        m_tready;
	logic [95:0] m_tdata;   // write_address[31:0], write_data[95:32]
	logic        m_tlast;   // last_of_run

	flash_phrase_write_combiner_core #(.PHRASE_BYTES(PHRASE)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	// shadow copy of the combiner state
	logic [7:0]  phrase_img [PHRASE];
	logic [31:0] open_base;
	int          fill_cnt;
	bit          open_phrase;
	logic [31:0] next_addr;

	result_t pending_phrases [$];
	result_t want;
	int      errors = 0;
	int      cycle_cnt = 0;
	int      send_idle_pct = 0;
	int      stall_pct = 0;

	initial clk = 1'b0;
	always #2 clk = ~clk;

	// open phrase as the block emits it, unfilled slots padded
	function automatic result_t phrase_result(input logic last);
		result_t r;
		r.waddr = open_base;
		for (int i = 0; i < OUT_BYTES; i++)
			r.wdata[8*i +: 8] = (i < PHRASE && i < fill_cnt) ? phrase_img[i] : PAD_BYTE;
		r.last = last;
		return r;
	endfunction

	// advance the shadow state by one beat and queue the phrases it emits
	function automatic void combine_beat(input logic mode, input logic rs,
			input logic [31:0] addr_in, input logic [7:0] data_in);
		result_t     made [$];
		logic [31:0] addr;
		logic [31:0] slot;
		if (mode == MODE_FLUSH) begin
			if (open_phrase) begin
				pending_phrases.push_back(phrase_result(1'b1));
				open_phrase = 0;
				fill_cnt = 0;
			end
			return;
		end
		addr = rs ? addr_in : next_addr;
		slot = open_base + 32'(fill_cnt);
		// break in continuity closes the open phrase
		if (open_phrase && addr != slot) begin
			made.push_back(phrase_result(1'b0));
			open_phrase = 0;
			fill_cnt = 0;
		end
		if (!open_phrase) begin
			open_base = (addr / PHRASE) * PHRASE;
			fill_cnt = addr % PHRASE;
			for (int j = 0; j < fill_cnt; j++)
				phrase_img[j] = PAD_BYTE;
			open_phrase = 1;
		end
		phrase_img[fill_cnt] = data_in;
		fill_cnt++;
		if (fill_cnt >= PHRASE) begin
			made.push_back(phrase_result(1'b1));
			open_phrase = 0;
			fill_cnt = 0;
		end else if (made.size() > 0) begin
			made[made.size()-1].last = 1'b1;
		end
		next_addr = addr + 32'd1;
		foreach (made[k])
			pending_phrases.push_back(made[k]);
	endfunction

	// drive one beat, wait for the handshake, then predict
	task automatic send_beat(input logic mode, input logic rs,
			input logic [31:0] addr, input logic [7:0] data);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= {rs, mode};
		s_tdata  <= {data, addr};
		do @(posedge clk); while (!s_tready);
		combine_beat(mode, rs, addr, data);
	endtask

	// receiver back-pressure
	always @(posedge clk)
		m_tready <= ($urandom_range(99) >= stall_pct);

	// compare every accepted phrase against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_phrases.size() == 0) begin
				$error("unexpected phrase: write_address %h write_data %h",
					m_tdata[31:0], m_tdata[95:32]);
				errors++;
			end else begin
				want = pending_phrases.pop_front();
				if (m_tdata[31:0] !== want.waddr) begin
					$error("write_address: expected %h, got %h", want.waddr, m_tdata[31:0]);
					errors++;
				end
				if (m_tdata[95:32] !== want.wdata) begin
					$error("write_data: expected %h, got %h", want.wdata, m_tdata[95:32]);
					errors++;
				end
				if (m_tlast !== want.last) begin
					$error("last_of_run: expected %b, got %b", want.last, m_tlast);
					errors++;
				end
			end
		end
	end

	// run watchdog
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("[flash_phrase_write_combiner_core] ERROR");
			$finish;
		end
	end

	// flush with nothing open, then a byte that takes the reset address
	task automatic test_reset_address;
		send_beat(MODE_FLUSH, 1'b1, 32'h1234_5678, 8'h5A);
		send_beat(MODE_DATA, 1'b0, 32'hFFFF_FFFF, 8'h00);
		// record start that lands on the next slot keeps the phrase open
		send_beat(MODE_DATA, 1'b1, 32'h0000_0001, 8'h11);
		send_beat(MODE_FLUSH, 1'b0, 32'h0, 8'h0);
	endtask

	// eight bytes from an aligned start fill one phrase
	task automatic test_full_phrase;
		send_beat(MODE_DATA, 1'b1, 32'h0000_1000, 8'h80);
		for (int i = 1; i < PHRASE; i++)
			send_beat(MODE_DATA, 1'b0, $urandom, 8'(8'h80 + i));
	endtask

	// jump to the top slot of another phrase: old phrase and new full phrase together
	task automatic test_break_and_full;
		send_beat(MODE_DATA, 1'b1, 32'h0000_0103, 8'hC3);
		send_beat(MODE_DATA, 1'b1, 32'h0000_0207, 8'h7E);
	endtask

	// top of the address space, wrap to zero, flush with every field set
	task automatic test_address_wrap;
		send_beat(MODE_DATA, 1'b1, 32'hFFFF_FFFE, 8'hFF);
		send_beat(MODE_DATA, 1'b0, 32'h0, 8'h00);
		send_beat(MODE_DATA, 1'b0, 32'h0, 8'hA5);
		send_beat(MODE_FLUSH, 1'b1, 32'hFFFF_FFFF, 8'hFF);
		// flush keeps the running address
		send_beat(MODE_DATA, 1'b0, 32'hFFFF_FFFF, 8'h3C);
		send_beat(MODE_FLUSH, 1'b0, 32'h0, 8'h0);
	endtask

	// records with random content, some flushes and some noise
	task automatic test_random_records(input int beats);
		int          sent;
		int          len;
		logic [31:0] start;
		sent = 0;
		while (sent < beats) begin
			case ($urandom_range(9))
				0, 1, 2, 3: start = 32'h0000_4000 + $urandom_range(0, 63);
				4, 5:       start = next_addr;
				6:          start = $urandom;
				7:          start = 32'hFFFF_FFF0 + $urandom_range(0, 15);
				8:          start = next_addr + $urandom_range(1, 9);
				default:    start = open_base + $urandom_range(0, PHRASE - 1);
			endcase
			len = ($urandom_range(9) == 0) ? $urandom_range(1, 24) : $urandom_range(1, 12);
			send_beat(MODE_DATA, 1'b1, start, 8'($urandom));
			for (int i = 1; i < len; i++) begin
				if ($urandom_range(19) == 0)
					send_beat(MODE_DATA, 1'b1, next_addr, 8'($urandom));
				else
					send_beat(MODE_DATA, 1'b0, $urandom, 8'($urandom));
			end
			sent += len;
			if ($urandom_range(99) < 15) begin
				send_beat(MODE_FLUSH, 1'($urandom), $urandom, 8'($urandom));
				sent++;
			end
			if ($urandom_range(99) < 10) begin
				send_beat(1'($urandom), 1'($urandom), $urandom, 8'($urandom));
				sent++;
			end
		end
	endtask

	// wait out every expected phrase plus the pipeline depth
	task automatic drain;
		s_tvalid <= 1'b0;
		stall_pct = 0;
		while (pending_phrases.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	initial begin
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		s_tuser  <= '0;
		m_tready <= 1'b0;
		open_base   = '0;
		fill_cnt    = 0;
		open_phrase = 0;
		next_addr   = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_address();
		test_full_phrase();
		test_break_and_full();
		test_address_wrap();

		// idle phases: none, sender, receiver, both
		send_idle_pct = 0;  stall_pct = 0;
		test_random_records(350);
		send_idle_pct = 85; stall_pct = 0;
		test_random_records(350);
		send_idle_pct = 0;  stall_pct = 85;
		test_random_records(350);
		send_idle_pct = 13; stall_pct = 13;
		test_random_records(350);

		drain();
		if (errors == 0)
			$display("[flash_phrase_write_combiner_core] OK");
		else
			$display("[flash_phrase_write_combiner_core] ERROR");
		$finish;
	end

endmodule
`default_nettype wire

// ----- filelist.f -----
design/fpwc_pkg.sv
design/fpwc_addr_stage.sv
design/fpwc_phrase_stage.sv
design/fpwc_out_fifo.sv
design/flash_phrase_write_combiner_core.sv
design/fpwc_checker.sv
test/flash_phrase_write_combiner_core_tb.sv
